### src/sha_pkg.sv
// Package for the SHA-256 stream hasher: round constants, initial hash,
// round and schedule functions, and the front-to-back command type.
`timescale 1ns / 1ps
package sha_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int LENGTH_AT   = 56;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_END  = 2'd1
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [7:0]   data;
      logic         has_byte;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FILL   = 3'd0,
      ST_ROUND  = 3'd1,
      ST_ADD    = 3'd2,
      ST_PAD    = 3'd3,
      ST_EMIT   = 3'd4
   } back_state_type;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] h [0:7];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

### src/sha_front.sv
// Front end: accepts request words, drops empty ones, and queues commands.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_byte_present,
   input  logic             req_end_of_message,
   output logic             cmd_valid,
   output sha_pkg::cmd_type cmd,
   input  logic             cmd_take
);

   localparam int PW = $clog2(sha_pkg::QUEUE_DEPTH);

   sha_pkg::cmd_type queue_ff [sha_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   count_ff, count_in;
   logic          push_ok, pop_ok;
   sha_pkg::cmd_type new_cmd;

   // Classify the incoming word; words with neither flag are dropped
   always_comb begin
      new_cmd.code     = req_end_of_message ? sha_pkg::CMD_END : sha_pkg::CMD_BYTE;
      new_cmd.data     = req_data_byte;
      new_cmd.has_byte = req_byte_present;
   end

   assign req_full  = (count_ff == (PW+1)'(sha_pkg::QUEUE_DEPTH));
   assign push_ok   = req_push && !req_full && (req_byte_present || req_end_of_message);
   assign cmd_valid = (count_ff != '0);
   assign pop_ok    = cmd_valid && cmd_take;
   assign cmd       = queue_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in    = push_ok ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop_ok ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PW+1)'(push_ok) - (PW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ff] <= new_cmd;
      end
   end

endmodule

### src/sha_back.sv
// Back end: block buffer, padding, one-round-per-cycle compression and
// digest word readout. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  sha_pkg::cmd_type cmd,
   output logic             cmd_take,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   sha_pkg::back_state_type state_ff, state_in;

   // Block store as 16 big-endian words; schedule window reuses it
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bytes_ff, bytes_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        final_ff, final_in;   // compression ends the message
   logic        second_ff, second_in; // length block still to go
   logic        byte_done_ff, byte_done_in; // byte of the head END word is stored
   logic [2:0]  emit_ff, emit_in;
   logic        out_valid_ff, out_valid_in;

   logic        wr_byte;
   logic [7:0]  wr_val;
   logic        shift_w, start_rnd, do_round, do_add, pad_len, clear_rest;
   logic [31:0] t1, t2, w_new;
   logic [63:0] bits;

   assign bits = {bytes_ff[60:0], 3'b000};

   // Round datapath
   always_comb begin
      t1 = v_ff[7] + sha_pkg::bsig1(v_ff[4]) +
           ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) +
           sha_pkg::round_const(rnd_ff) + w_ff[0];
      t2 = sha_pkg::bsig0(v_ff[0]) +
           ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = w_ff[0] + sha_pkg::sig0(w_ff[1]) + w_ff[9] + sha_pkg::sig1(w_ff[14]);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bytes_in     = bytes_ff;
      rnd_in       = rnd_ff;
      final_in     = final_ff;
      second_in    = second_ff;
      byte_done_in = byte_done_ff;
      emit_in      = emit_ff;
      out_valid_in = out_valid_ff;
      cmd_take     = 1'b0;
      wr_byte      = 1'b0;
      wr_val       = cmd.data;
      start_rnd    = 1'b0;
      do_round     = 1'b0;
      do_add       = 1'b0;
      pad_len      = 1'b0;
      clear_rest   = 1'b0;
      shift_w      = 1'b0;
      case (state_ff)
         sha_pkg::ST_FILL: begin
            if (cmd_valid) begin
               if (cmd.has_byte && !byte_done_ff) begin
                  // Store the message byte; hold END in queue until its byte is in
                  wr_byte  = 1'b1;
                  bytes_in = bytes_ff + 64'd1;
                  fill_in  = fill_ff + 6'd1;
                  if (cmd.code != sha_pkg::CMD_END) begin
                     cmd_take = 1'b1;
                  end else begin
                     byte_done_in = 1'b1;
                  end
                  if (fill_ff == 6'd63) begin
                     start_rnd = 1'b1;
                     state_in  = sha_pkg::ST_ROUND;
                     final_in  = 1'b0;
                  end
               end else begin
                  // End mark: append the pad byte
                  cmd_take = 1'b1;
                  byte_done_in = 1'b0;
                  wr_byte  = 1'b1;
                  wr_val   = 8'h80;
                  clear_rest = 1'b1;
                  state_in = sha_pkg::ST_PAD;
                  second_in = (fill_ff >= 6'(sha_pkg::LENGTH_AT));
               end
            end
         end
         sha_pkg::ST_PAD: begin
            if (second_ff) begin
               // Length does not fit: compress this block first
               start_rnd = 1'b1;
               final_in  = 1'b0;
               state_in  = sha_pkg::ST_ROUND;
            end else begin
               pad_len   = 1'b1;
               start_rnd = 1'b1;
               final_in  = 1'b1;
               state_in  = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            do_round = 1'b1;
            shift_w  = 1'b1;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = sha_pkg::ST_ADD;
            end
         end
         sha_pkg::ST_ADD: begin
            do_add  = 1'b1;
            fill_in = '0;
            if (final_ff) begin
               emit_in      = '0;
               out_valid_in = 1'b1;
               state_in     = sha_pkg::ST_EMIT;
            end else if (second_ff) begin
               second_in = 1'b0;
               clear_rest = 1'b1;
               state_in  = sha_pkg::ST_PAD;
            end else begin
               state_in = sha_pkg::ST_FILL;
            end
         end
         sha_pkg::ST_EMIT: begin
            if (rsp_pop) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  out_valid_in = 1'b0;
                  bytes_in     = '0;
                  fill_in      = '0;
                  state_in     = sha_pkg::ST_FILL;
               end
            end
         end
         default: state_in = sha_pkg::ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha_pkg::ST_FILL;
         fill_ff      <= '0;
         bytes_ff     <= '0;
         rnd_ff       <= '0;
         final_ff     <= 1'b0;
         second_ff    <= 1'b0;
         byte_done_ff <= 1'b0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bytes_ff     <= bytes_in;
         rnd_ff       <= rnd_in;
         final_ff     <= final_in;
         second_ff    <= second_in;
         byte_done_ff <= byte_done_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Block words and schedule window
   always_ff @(posedge clock) begin
      if (wr_byte) begin
         case (fill_ff[1:0])
            2'd0:    w_ff[fill_ff[5:2]][31:24] <= wr_val;
            2'd1:    w_ff[fill_ff[5:2]][23:16] <= wr_val;
            2'd2:    w_ff[fill_ff[5:2]][15:8]  <= wr_val;
            default: w_ff[fill_ff[5:2]][7:0]   <= wr_val;
         endcase
      end
      if (clear_rest) begin
         // Zero every byte past the pad (or whole block on the extra block)
         for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
               if (state_ff == sha_pkg::ST_ADD || (i * 4 + b) > int'(fill_ff)) begin
                  w_ff[i][31-8*b -: 8] <= 8'h00;
               end
            end
         end
      end
      if (pad_len) begin
         w_ff[14] <= bits[63:32];
         w_ff[15] <= bits[31:0];
      end
      if (shift_w) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
      end
   end

   // Working variables and hash state
   always_ff @(posedge clock) begin
      if (start_rnd) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (do_round) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (state_ff == sha_pkg::ST_EMIT && rsp_pop && emit_ff == 3'd7)) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha_pkg::init_hash(3'(i));
         end
      end else if (do_add) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_digest_word = h_ff[emit_ff];
   assign rsp_word_index  = emit_ff;
   assign rsp_last_word   = (emit_ff == 3'd7);

endmodule

### src/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: front queue plus compression back end.
// Depends on sha_pkg, sha_front and sha_back.
`timescale 1ns / 1ps
// Streaming SHA-256. Push one word per message byte (byte_present) and mark
// the last with end_of_message; a word with no byte and the end mark hashes
// the empty message. The front takes words into a four-entry queue; the back
// end stores one byte per cycle while it is filling a block and, after the
// 64th byte of a block, runs 64 rounds and then folds the result into the
// hash, taking no bytes meanwhile. An end word that carries a byte stores its
// byte first and its end mark after. At the end, padding adds one or two
// compressions (each a setup step, 64 rounds and a fold step), then the eight
// digest words come out in order on the rsp_ ports, word 0 first, while new
// message words queue up in front.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic             cmd_valid, cmd_take;
   sha_pkg::cmd_type cmd;

   sha_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (push),
      .req_full           (full),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_take           (cmd_take)
   );

   sha_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

### verif/tb_sha256_stream_hasher.sv
// Testbench for the SHA-256 stream hasher: drives byte words, predicts each
// digest with its own SHA-256 model and checks every digest word in order.
// Depends on sha256_stream_hasher (and sha_pkg through it).
`timescale 1ns / 1ps

typedef struct packed {
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
} digest_out_type;

class digest_scoreboard;
   logic [31:0] hash_acc [8];
   logic [7:0]  block_buf [64];
   int unsigned fill_count;
   logic [63:0] byte_count;
   digest_out_type pending_words [$];
   int unsigned fail_count;

   function new();
      restart_message();
      fail_count = 0;
   endfunction

   function void restart_message();
      hash_acc = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill_count = 0;
      byte_count = '0;
   endfunction

   function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds over the gathered block and fold into the hash.
   function void compress_block();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] kr [64];
      logic [31:0] t1, t2, s0, s1;
      kr = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 16; i++)
         sched[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kr[i] + sched[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
   endfunction

   // Absorb one accepted word; on the end mark, pad and queue the digest.
   function void note_word(logic [7:0] data, logic has_byte, logic eom);
      logic [63:0] bit_len;
      if (has_byte) begin
         block_buf[fill_count] = data;
         fill_count++;
         byte_count++;
         if (fill_count == 64) begin
            compress_block();
            fill_count = 0;
         end
      end
      if (!eom) return;
      bit_len = byte_count << 3;
      block_buf[fill_count] = 8'h80;
      fill_count++;
      if (fill_count > 56) begin
         for (int i = fill_count; i < 64; i++) block_buf[i] = 8'h00;
         compress_block();
         fill_count = 0;
      end
      for (int i = fill_count; i < 56; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_buf[63-i] = bit_len[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
         pending_words.push_back('{hash_acc[i], 3'(i), i == 7});
      restart_message();
   endfunction

   // Compare one popped digest word with the oldest prediction.
   function void check_word(digest_out_type got);
      digest_out_type want;
      if (pending_words.size() == 0) begin
         $error("unexpected digest word %h", got.digest_word);
         fail_count++;
         return;
      end
      want = pending_words.pop_front();
      if (got.digest_word !== want.digest_word) begin
         $error("digest_word: expected %h actual %h", want.digest_word, got.digest_word);
         fail_count++;
      end
      if (got.word_index !== want.word_index) begin
         $error("word_index: expected %0d actual %0d", want.word_index, got.word_index);
         fail_count++;
      end
      if (got.last_word !== want.last_word) begin
         $error("last_word: expected %0d actual %0d", want.last_word, got.last_word);
         fail_count++;
      end
   endfunction
endclass

module tb_sha256_stream_hasher;
   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_end_of_message;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard board;
   bit          hold_readout;
   int          items_sent;
   longint      cycle_count;

   localparam longint CYCLE_LIMIT = 400000;

   sha256_stream_hasher dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Send one word: optional random gap, then hold push until accepted.
   task automatic send_word(logic [7:0] data, logic has_byte, logic eom);
      int gap;
      bit taken;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= data;
      req_byte_present <= has_byte;
      req_end_of_message <= eom;
      // Sample full mid-cycle, where it is stable up to the next edge
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      board.note_word(data, has_byte, eom);
   endtask

   // Send a whole message of given length with random bytes, and now and then a no-op word.
   task automatic send_message(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, i == len - 1);
      end
      if (len == 0) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic drain_digests();
      push <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
   endtask

   // Pop side: random stalls, plus one long hold-off when asked.
   initial begin
      int stall;
      digest_out_type got;
      pop <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_readout) begin
            pop <= 1'b0;
            repeat (300) @(posedge clock);
            hold_readout = 1'b0;
         end
         stall = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         // Capture the word mid-cycle, then take it at the next edge
         do @(negedge clock); while (empty);
         got = '{rsp_digest_word, rsp_word_index, rsp_last_word};
         @(posedge clock);
         board.check_word(got);
      end
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int len;
      board = new();
      hold_readout = 1'b0;
      items_sent = 0;
      reset <= 1'b1;
      push <= 1'b0;
      req_data_byte <= '0;
      req_byte_present <= 1'b0;
      req_end_of_message <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, no-op words, extreme bytes, one-byte message.
      send_word(8'hff, 1'b0, 1'b1);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h55, 1'b1, 1'b1);
      send_word(8'haa, 1'b1, 1'b1);
      drain_digests();

      // Hold the readout long enough that the block backs up.
      hold_readout = 1'b1;
      for (int m = 0; m < 6; m++) send_message($urandom_range(0, 3));
      drain_digests();

      // Padding boundaries: 56 spills into a length block, 64 is a full block.
      send_message(56);
      send_message(64);
      drain_digests();

      // Random short messages up to the item budget.
      while (items_sent < 160) begin
         len = $urandom_range(0, 12);
         send_message(len);
      end
      drain_digests();
      repeat (200) @(posedge clock);

      if (board.fail_count == 0 && board.pending_words.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

### filelist.f
src/sha_pkg.sv
src/sha_front.sv
src/sha_back.sv
src/sha256_stream_hasher.sv
verif/tb_sha256_stream_hasher.sv
